### hdl/fvg_pkg.sv
// Shared types, widths and constants for the polygon fan vertex generator.
package fvg_pkg;

    localparam int unsigned IDX_W   = 9;   // vertex index and segment count
    localparam int unsigned ANGLE_W = 16;  // angle in 1/65536 turn
    localparam int unsigned COORD_W = 16;  // signed Q8.8 coordinate
    localparam int unsigned RAD_W   = 15;  // unsigned Q7.8 radius
    localparam int unsigned TEX_W   = 2;   // texture coordinate in halves

    // Lowest segment count the clamp allows
    localparam logic [IDX_W-1:0] N_MIN = IDX_W'(3);

    // Texture codes in halves
    localparam logic [TEX_W-1:0] TEX_ZERO = 2'd0;
    localparam logic [TEX_W-1:0] TEX_HALF = 2'd1;
    localparam logic [TEX_W-1:0] TEX_ONE  = 2'd2;

    // Quadrant sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_C1 = 17'd102954;
    localparam logic [15:0] SIN_C3 = 16'd42334;
    localparam logic [12:0] SIN_C5 = 13'd5223;
    localparam logic [8:0]  SIN_C7 = 9'd307;

    localparam logic [14:0] QUARTER_TURN = 15'd16384;  // one quadrant of offset
    localparam logic [16:0] SINE_CAP     = 17'd65536;  // 1.0 in Q16
    localparam logic [32:0] ROUND_HALF   = 33'd32768;  // 0.5 before >>16

    // Register stages through one sine lane
    localparam int unsigned SINE_LAT = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SEGMENTS    = 2'd0,
        CFG_RADIUS      = 2'd1,
        CFG_START_ANGLE = 2'd2,
        CFG_DEPTH       = 2'd3
    } t_cfg_idx;

    // Per-vertex attributes decided at entry and carried down the pipe
    typedef struct packed {
        logic              in_range;
        logic              center;
        logic [TEX_W-1:0]  tex_u;
        logic [TEX_W-1:0]  tex_v;
        logic [IDX_W-1:0]  fan_next;
    } t_side;

    // What one division cell hands to the next
    typedef struct packed {
        t_side              side;
        logic [IDX_W-1:0]   rem;
        logic [ANGLE_W-1:0] quo;
    } t_div_beat;

endpackage

### hdl/fvg_div_cell.sv
// One restoring-division cell: retires one quotient bit of (v-1)*65536 / n.
module fvg_div_cell
    import fvg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_div_beat        i_beat,
    input  logic [IDX_W-1:0] i_n,
    output logic             o_valid,
    output t_div_beat        o_beat
);

    logic            r_valid;
    t_div_beat       r_beat;
    t_div_beat       n_beat;
    logic [IDX_W:0]  w_shift;
    logic [IDX_W:0]  w_diff;
    logic            w_ge;

    // Shift in a zero dividend bit, subtract the divisor when it fits
    always_comb begin
        w_shift       = {i_beat.rem, 1'b0};
        w_ge          = (w_shift >= {1'b0, i_n});
        w_diff        = w_shift - {1'b0, i_n};
        n_beat.side   = i_beat.side;
        n_beat.rem    = w_ge ? w_diff[IDX_W-1:0] : w_shift[IDX_W-1:0];
        n_beat.quo    = {i_beat.quo[ANGLE_W-2:0], w_ge};
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### hdl/fvg_sine_lane.sv
// Pipelined radius * sin(angle) lane, quadrant-folded odd polynomial.
module fvg_sine_lane
    import fvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [ANGLE_W-1:0] i_angle,
    input  logic [RAD_W-1:0]   i_radius,
    output logic [COORD_W-1:0] o_pos
);

    // Stage registers, numbered by stage
    logic [16:0]        r_x1, r_x2, r_x3, r_x4, r_x5;
    logic [16:0]        r_sq2, r_sq3, r_sq4;
    logic [12:0]        r_p3;
    logic [15:0]        r_p4;
    logic [16:0]        r_p5;
    logic [16:0]        r_s6;
    logic [15:0]        r_mag7;
    logic [COORD_W-1:0] r_pos8;
    logic [6:0]         r_neg;

    logic [16:0]        n_x1;
    logic [16:0]        n_sq2;
    logic [12:0]        n_p3;
    logic [15:0]        n_p4;
    logic [16:0]        n_p5;
    logic [16:0]        n_s6;
    logic [15:0]        n_mag7;
    logic [COORD_W-1:0] n_pos8;

    logic [14:0]        w_off;
    logic [33:0]        w_sqr;
    logic [25:0]        w_t3;
    logic [29:0]        w_t4;
    logic [32:0]        w_t5;
    logic [33:0]        w_t6;
    logic [31:0]        w_p7;
    logic [32:0]        w_t7;

    always_comb begin
        // Fold the angle into the first quadrant, scale to Q16
        w_off  = i_angle[ANGLE_W-2] ? (QUARTER_TURN - {1'b0, i_angle[ANGLE_W-3:0]})
                                    : {1'b0, i_angle[ANGLE_W-3:0]};
        n_x1   = {w_off, 2'b00};
        // Square
        w_sqr  = r_x1 * r_x1;
        n_sq2  = w_sqr[32:16];
        // Horner steps
        w_t3   = SIN_C7 * r_sq2;
        n_p3   = SIN_C5 - {3'b000, w_t3[25:16]};
        w_t4   = r_p3 * r_sq3;
        n_p4   = SIN_C3 - {2'b00, w_t4[29:16]};
        w_t5   = r_p4 * r_sq4;
        n_p5   = SIN_C1 - w_t5[32:16];
        // Final odd term, capped at one
        w_t6   = r_p5 * r_x5;
        n_s6   = ({1'b0, w_t6[33:16]} > {1'b0, SINE_CAP}) ? SINE_CAP : w_t6[32:16];
        // Scale by radius with rounding
        w_p7   = r_s6 * i_radius;
        w_t7   = {1'b0, w_p7} + ROUND_HALF;
        n_mag7 = w_t7[31:16];
        // Apply the lower half-turn sign
        n_pos8 = r_neg[6] ? (COORD_W'(0) - r_mag7) : r_mag7;
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= n_x1;
            r_x2   <= r_x1;
            r_sq2  <= n_sq2;
            r_x3   <= r_x2;
            r_sq3  <= r_sq2;
            r_p3   <= n_p3;
            r_x4   <= r_x3;
            r_sq4  <= r_sq3;
            r_p4   <= n_p4;
            r_x5   <= r_x4;
            r_p5   <= n_p5;
            r_s6   <= n_s6;
            r_mag7 <= n_mag7;
            r_pos8 <= n_pos8;
            r_neg  <= {r_neg[5:0], i_angle[ANGLE_W-1]};
        end
    end

    assign o_pos = r_pos8;

endmodule

### hdl/polygon_fan_vertex_generator.sv
// Top level: regular polygon triangle fan vertex generator.
//
//  channel   | dir | beat moves
//  s_axis    | in  | tdata[8:0] vertex_index
//  m_axis    | out | tdata pos_x, pos_y, pos_z, tex_u, tex_v, fan_next; tuser in_range
//  cfg       | in  | i_cfg_index selects segments/radius/start_angle/depth, i_cfg_data value
//
// One vertex per clock sustained while m_axis is ready. The pipe is 16 division cells
// (one quotient bit each), 8 sine stages, and the output register.
// Synchronous active-low reset clears all valid flags and loads register defaults.
// A stall on m_axis freezes the whole pipe; a one-beat skid register at the
// input takes the beat offered in that cycle, so s_axis_tready is registered.
module polygon_fan_vertex_generator
    import fvg_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Vertex requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] vertex_index
    // Vertices
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z,
                                        // [49:48] tex_u, [51:50] tex_v, [60:52] fan_next
    output logic        m_axis_tuser,   // [0] in_range
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned IDX_MAX  = (1 << IDX_W) - 1;
    localparam int unsigned CLAMP_HI = (MAX_SEGMENTS > IDX_MAX) ? IDX_MAX : MAX_SEGMENTS;
    localparam logic [IDX_W-1:0] N_MAX = IDX_W'(CLAMP_HI);

    // Configuration registers
    logic [IDX_W-1:0]   r_cfg_segments;
    logic [RAD_W-1:0]   r_cfg_radius;
    logic [ANGLE_W-1:0] r_cfg_start;
    logic [COORD_W-1:0] r_cfg_depth;

    // Skid and output registers
    logic               r_skid_valid;
    logic [IDX_W-1:0]   r_skid_data;
    logic               r_out_valid;
    logic [63:0]        r_out_data;
    logic               r_out_user;
    logic [63:0]        n_out_data;

    // Sideband alongside the sine lanes
    logic               r_sp_valid [SINE_LAT];
    t_side              r_sp_side  [SINE_LAT];

    logic               w_en;
    logic               w_entry_valid;
    logic [IDX_W-1:0]   w_v;
    logic [IDX_W-1:0]   w_n;
    logic [IDX_W-1:0]   w_vm1;
    t_side              w_side;
    logic               w_dv  [ANGLE_W+1];
    t_div_beat          w_div [ANGLE_W+1];
    logic [ANGLE_W-1:0] w_ax;
    logic [ANGLE_W-1:0] w_ay;
    logic [COORD_W-1:0] w_sx;
    logic [COORD_W-1:0] w_sy;
    t_side              w_oside;
    logic               w_rim;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign o_cfg_ready   = 1'b1;

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_segments <= IDX_W'(4);
            r_cfg_radius   <= RAD_W'(256);
            r_cfg_start    <= '0;
            r_cfg_depth    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEGMENTS:    r_cfg_segments <= i_cfg_data[IDX_W-1:0];
                CFG_RADIUS:      r_cfg_radius   <= i_cfg_data[RAD_W-1:0];
                CFG_START_ANGLE: r_cfg_start    <= i_cfg_data;
                CFG_DEPTH:       r_cfg_depth    <= i_cfg_data;
            endcase
        end
    end

    // Hold an accepted beat while the pipe is frozen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && s_axis_tvalid && s_axis_tready) begin
            r_skid_data <= s_axis_tdata[IDX_W-1:0];
        end
    end

    // Entry: clamp the count, decide range, center, texture and fan corner
    always_comb begin
        w_entry_valid = r_skid_valid || (s_axis_tvalid && s_axis_tready);
        w_v           = r_skid_valid ? r_skid_data : s_axis_tdata[IDX_W-1:0];
        if (r_cfg_segments < N_MIN) begin
            w_n = N_MIN;
        end else if (r_cfg_segments > N_MAX) begin
            w_n = N_MAX;
        end else begin
            w_n = r_cfg_segments;
        end
        w_vm1           = w_v - IDX_W'(1);
        w_side          = '0;
        w_side.in_range = (w_v <= w_n);
        w_side.center   = (w_v == '0);
        if (!w_side.in_range) begin
            w_side = '0;
        end else if (w_side.center) begin
            w_side.tex_u = TEX_HALF;
            w_side.tex_v = TEX_HALF;
        end else begin
            case (w_vm1[1:0])
                2'd0: begin w_side.tex_u = TEX_ONE;  w_side.tex_v = TEX_ZERO; end
                2'd1: begin w_side.tex_u = TEX_ONE;  w_side.tex_v = TEX_ONE;  end
                2'd2: begin w_side.tex_u = TEX_ZERO; w_side.tex_v = TEX_ONE;  end
                default: begin w_side.tex_u = TEX_ZERO; w_side.tex_v = TEX_ZERO; end
            endcase
            w_side.fan_next = (w_v == w_n) ? IDX_W'(1) : (w_v + IDX_W'(1));
        end
        w_dv[0]       = w_entry_valid;
        w_div[0].side = w_side;
        w_div[0].rem  = w_vm1;
        w_div[0].quo  = '0;
    end

    // Division chain: one quotient bit per cell
    for (genvar g = 0; g < ANGLE_W; g++) begin : g_div
        fvg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_beat  (w_div[g]),
            .i_n     (w_n),
            .o_valid (w_dv[g+1]),
            .o_beat  (w_div[g+1])
        );
    end

    // Rim angle; cosine is the sine a quarter turn on
    assign w_ax = r_cfg_start + w_div[ANGLE_W].quo;
    assign w_ay = {w_ax[ANGLE_W-1:ANGLE_W-2] + 2'd1, w_ax[ANGLE_W-3:0]};

    fvg_sine_lane u_sin_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  (w_ax),
        .i_radius (r_cfg_radius),
        .o_pos    (w_sx)
    );

    fvg_sine_lane u_sin_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  (w_ay),
        .i_radius (r_cfg_radius),
        .o_pos    (w_sy)
    );

    // Carry valid and attributes beside the sine lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SINE_LAT; i++) begin
                r_sp_valid[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_sp_valid[0] <= w_dv[ANGLE_W];
            for (int i = 1; i < SINE_LAT; i++) begin
                r_sp_valid[i] <= r_sp_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sp_side[0] <= w_div[ANGLE_W].side;
            for (int i = 1; i < SINE_LAT; i++) begin
                r_sp_side[i] <= r_sp_side[i-1];
            end
        end
    end

    // Assemble the vertex beat
    always_comb begin
        w_oside    = r_sp_side[SINE_LAT-1];
        w_rim      = w_oside.in_range && !w_oside.center;
        n_out_data = '0;
        n_out_data[15:0]  = w_rim ? w_sx : '0;
        n_out_data[31:16] = w_rim ? w_sy : '0;
        n_out_data[47:32] = w_oside.in_range ? r_cfg_depth : '0;
        n_out_data[49:48] = w_oside.tex_u;
        n_out_data[51:50] = w_oside.tex_v;
        n_out_data[60:52] = w_oside.fan_next;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_sp_valid[SINE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_user <= w_oside.in_range;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Out-of-range vertices carry an all-zero payload
    a_out_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("out-of-range vertex with nonzero payload");

    // The center vertex sits at the origin with texture at the middle
    a_center_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && (m_axis_tdata[60:52] == 9'd0)) |->
        ((m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[49:48] == TEX_HALF) &&
         (m_axis_tdata[51:50] == TEX_HALF)))
        else $error("center vertex malformed");

    // A skidded beat survives a frozen pipe unchanged
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_en) |=> (r_skid_valid && $stable(r_skid_data)))
        else $error("skid beat lost during stall");

    // A frozen pipe never loses its head beat
    a_pipe_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_sp_valid[SINE_LAT-1]) |=> r_sp_valid[SINE_LAT-1])
        else $error("pipe advanced while stalled");

endmodule

### verif/testbench.sv
// Self-checking testbench for the polygon fan vertex generator.
`timescale 1ns / 100ps

module testbench;
    import fvg_pkg::*;

    localparam int unsigned MAX_SEGS       = 256;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int unsigned DRAIN_CYCLES   = 30;    // pipe latency plus margin
    localparam int unsigned LONG_HOLD      = 300;   // output stall that fills the pipe
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS    = 62;

    // One expected output vertex
    typedef struct packed {
        logic [IDX_W-1:0]   req_index;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
        logic [IDX_W-1:0]   fan_next;
        logic               in_range;
    } t_vertex;

    // Register shadow, vertex predictor and queue of vertices still owed by the block
    class fan_vertex_scoreboard;
        logic [IDX_W-1:0]   segments;
        logic [RAD_W-1:0]   radius;
        logic [ANGLE_W-1:0] start_angle;
        logic [COORD_W-1:0] depth;
        t_vertex            pending_vertices[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        rim_seen;
        int unsigned        outside_seen;

        function new();
            segments     = 9'd4;
            radius       = 15'd256;
            start_angle  = 16'd0;
            depth        = 16'd0;
            errors       = 0;
            checked      = 0;
            rim_seen     = 0;
            outside_seen = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_SEGMENTS:    segments    = value[IDX_W-1:0];
                CFG_RADIUS:      radius      = value[RAD_W-1:0];
                CFG_START_ANGLE: start_angle = value[ANGLE_W-1:0];
                CFG_DEPTH:       depth       = value[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp the programmed count to the supported range
        function int unsigned effective_segments();
            int unsigned n;
            n = 32'(segments);
            if (n < N_MIN) n = 32'(N_MIN);
            if (n > MAX_SEGS) n = MAX_SEGS;
            return n;
        endfunction

        // Odd polynomial over one quadrant, Q16 in and out, capped at 1.0
        function logic [63:0] quadrant_sine(logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] p;
            logic [63:0] s;
            x2 = (x * x) >> 16;
            p  = 64'(SIN_C7);
            p  = 64'(SIN_C5) - ((p * x2) >> 16);
            p  = 64'(SIN_C3) - ((p * x2) >> 16);
            p  = 64'(SIN_C1) - ((p * x2) >> 16);
            s  = (p * x) >> 16;
            return (s > 64'(SINE_CAP)) ? 64'(SINE_CAP) : s;
        endfunction

        // radius * sin(angle), rounded, sign applied after rounding
        function logic [COORD_W-1:0] scaled_sine(logic [63:0] angle);
            logic [63:0] a;
            logic [63:0] f;
            logic [63:0] mag;
            logic [1:0]  quadrant;
            a        = angle & 64'hFFFF;
            quadrant = a[15:14];
            f        = a & 64'h3FFF;
            if (quadrant[0]) f = 64'(QUARTER_TURN) - f;
            mag = (quadrant_sine(f << 2) * 64'(radius) + 64'(ROUND_HALF)) >> 16;
            if (quadrant[1]) mag = 64'd0 - mag;
            return mag[COORD_W-1:0];
        endfunction

        function t_vertex predict_vertex(logic [IDX_W-1:0] vtx);
            t_vertex     r;
            logic [63:0] n;
            logic [63:0] vv;
            logic [63:0] ang;
            logic [1:0]  corner;
            r           = '0;
            r.req_index = vtx;
            n           = 64'(effective_segments());
            vv          = 64'(vtx);
            // Past the last rim vertex everything reads zero
            if (vv > n) return r;
            r.in_range = 1'b1;
            r.pos_z    = depth;
            if (vv == 0) begin
                r.tex_u = TEX_HALF;
                r.tex_v = TEX_HALF;
                return r;
            end
            ang     = (64'(start_angle) + ((vv - 1) * 64'd65536) / n) & 64'hFFFF;
            r.pos_x = scaled_sine(ang);
            r.pos_y = scaled_sine(ang + 64'(QUARTER_TURN));
            // Texture corners repeat every four rim vertices
            corner  = vtx[1:0] - 2'd1;
            case (corner)
                2'd0: begin r.tex_u = TEX_ONE;  r.tex_v = TEX_ZERO; end
                2'd1: begin r.tex_u = TEX_ONE;  r.tex_v = TEX_ONE;  end
                2'd2: begin r.tex_u = TEX_ZERO; r.tex_v = TEX_ONE;  end
                default: begin r.tex_u = TEX_ZERO; r.tex_v = TEX_ZERO; end
            endcase
            // Last rim vertex closes the fan back to vertex 1
            r.fan_next = (vv == n) ? IDX_W'(1) : IDX_W'(vv + 1);
            return r;
        endfunction

        function void note_request(logic [IDX_W-1:0] vtx);
            t_vertex exp_v;
            exp_v = predict_vertex(vtx);
            if (!exp_v.in_range) outside_seen++;
            else if (vtx != 0) rim_seen++;
            pending_vertices.push_back(exp_v);
        endfunction

        function void compare_field(string field, logic [IDX_W-1:0] vtx,
                                    logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: vertex %0d %s expected 0x%h actual 0x%h",
                         $time, vtx, field, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_vertex(logic [63:0] data, logic user);
            t_vertex exp_v;
            if (pending_vertices.size() == 0) begin
                $display("%0t: vertex beat with nothing expected, expected none actual 0x%h",
                         $time, data);
                errors++;
                return;
            end
            exp_v = pending_vertices.pop_front();
            compare_field("pos_x", exp_v.req_index, exp_v.pos_x, data[15:0]);
            compare_field("pos_y", exp_v.req_index, exp_v.pos_y, data[31:16]);
            compare_field("pos_z", exp_v.req_index, exp_v.pos_z, data[47:32]);
            compare_field("tex_u", exp_v.req_index, 16'(exp_v.tex_u), 16'(data[49:48]));
            compare_field("tex_v", exp_v.req_index, 16'(exp_v.tex_v), 16'(data[51:50]));
            compare_field("fan_next", exp_v.req_index, 16'(exp_v.fan_next), 16'(data[60:52]));
            compare_field("in_range", exp_v.req_index, 16'(exp_v.in_range), 16'(user));
            checked++;
        endfunction

        function int unsigned pending();
            return pending_vertices.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [8:0] vertex_index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z,
                                 // [49:48] tex_u, [51:50] tex_v, [60:52] fan_next
    logic        m_axis_tuser;   // [0] in_range
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    fan_vertex_scoreboard sb;
    bit          idle_on;
    bit          long_hold_req;
    int unsigned settings_count;
    int unsigned quiet_cycles;

    polygon_fan_vertex_generator #(
        .MAX_SEGMENTS(MAX_SEGS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every accepted output beat
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_vertex(m_axis_tdata, m_axis_tuser);
    end

    // End the run when no channel moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Output backpressure: random stall bursts, one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Offer one vertex request, hold it until accepted; valid stays high after
    task automatic send_vertex(input logic [IDX_W-1:0] vtx);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, vtx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(vtx);
    endtask

    // Stop offering and wait until every owed vertex has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
    endtask

    // Write all four registers; only called with the pipe empty
    task automatic program_config(input logic [15:0] seg, input logic [15:0] rad,
                                  input logic [15:0] start, input logic [15:0] dep);
        write_register(CFG_SEGMENTS, seg);
        write_register(CFG_RADIUS, rad);
        write_register(CFG_START_ANGLE, start);
        write_register(CFG_DEPTH, dep);
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Mostly small fans so wrap and texture cycles repeat; clamps and extremes now and then
    task automatic random_config();
        logic [15:0] seg;
        logic [15:0] rad;
        logic [15:0] start;
        logic [15:0] dep;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       seg = 16'($urandom_range(0, 2));
            1:       seg = 16'($urandom_range(257, 511));
            2:       seg = 16'd3;
            3:       seg = 16'(MAX_SEGS);
            4, 5, 6, 7, 8, 9, 10, 11, 12: seg = 16'($urandom_range(3, 24));
            default: seg = 16'($urandom_range(3, MAX_SEGS));
        endcase
        seg[15:9] = 7'($urandom);
        pick = $urandom_range(0, 7);
        rad = (pick == 0) ? 16'd0 : (pick == 1) ? 16'h7FFF : 16'($urandom);
        rad[15] = 1'($urandom);
        pick = $urandom_range(0, 7);
        start = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(0, 7);
        dep = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
        program_config(seg, rad, start, dep);
    endtask

    // Fan walks in order, random rim and center picks, a few past the rim or anywhere
    function automatic logic [IDX_W-1:0] pick_vertex(input logic [IDX_W-1:0] prev);
        int unsigned n;
        int unsigned pick;
        n    = sb.effective_segments();
        pick = $urandom_range(0, 99);
        if (pick < 40) return (prev >= n) ? IDX_W'(0) : prev + IDX_W'(1);
        if (pick < 80) return IDX_W'($urandom_range(0, n));
        if (pick < 90) return IDX_W'($urandom_range(n + 1, n + 4));
        return IDX_W'($urandom_range(0, 511));
    endfunction

    task automatic run_random_phase(input int unsigned count, input bit hold_output,
                                    input bit pause_input);
        logic [IDX_W-1:0] vtx;
        random_config();
        vtx = '0;
        for (int unsigned i = 0; i < count; i++) begin
            if (hold_output && i == 4) long_hold_req = 1'b1;
            if (pause_input && i == count / 2) drain_results();
            vtx = pick_vertex(vtx);
            send_vertex(vtx);
        end
        drain_results();
    endtask

    initial begin
        logic [IDX_W-1:0] directed_q[$];
        sb             = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SEGMENTS;
        i_cfg_data     = '0;
        idle_on        = 1'b1;
        long_hold_req  = 1'b0;
        settings_count = 0;
        quiet_cycles   = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: square fan, center, every rim vertex, past the rim, all ones
        directed_q = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd511};
        foreach (directed_q[i]) send_vertex(directed_q[i]);
        drain_results();

        // Smallest fan, largest radius, start angle wraps, most negative depth
        program_config(16'd3, 16'h7FFF, 16'hFFFF, 16'h8000);
        directed_q = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4};
        foreach (directed_q[i]) send_vertex(directed_q[i]);
        drain_results();

        // Largest fan: quadrant boundaries hit the sine cap, last vertex wraps
        program_config(16'd256, 16'h7FFF, 16'd0, 16'h7FFF);
        directed_q = '{9'd1, 9'd65, 9'd129, 9'd193, 9'd256, 9'd257};
        foreach (directed_q[i]) send_vertex(directed_q[i]);
        drain_results();

        // Count below the minimum clamps up to three; zero radius
        program_config(16'd0, 16'd0, 16'd16384, 16'h1234);
        directed_q = '{9'd0, 9'd1, 9'd3, 9'd4};
        foreach (directed_q[i]) send_vertex(directed_q[i]);
        drain_results();

        // Count above the maximum clamps down
        program_config(16'd511, 16'd12345, 16'd777, 16'hFF00);
        directed_q = '{9'd255, 9'd256, 9'd257};
        foreach (directed_q[i]) send_vertex(directed_q[i]);
        drain_results();

        // Random settings and traffic; no idling in the last two phases
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 2) idle_on = 1'b0;
            run_random_phase(PHASE_ITEMS, p == 2, p == 5);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d vertices under %0d register settings (%0d rim, %0d past the rim)",
                 sb.checked, settings_count + 1, sb.rim_seen, sb.outside_seen);
        $display("included clamped segment counts, a long output stall and a full drain pause");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hdl/fvg_pkg.sv
hdl/fvg_div_cell.sv
hdl/fvg_sine_lane.sv
hdl/polygon_fan_vertex_generator.sv
verif/testbench.sv
